// ===== hw/rtl/hrhp_pkg.sv =====
// package for the http request header parser
// holds phase codes, result codes, token strings and match helpers; no dependencies
`default_nettype none

package hrhp_pkg;

   localparam int LENGTH_BITS_DEF   = 32;
   localparam int MAX_LINE_BITS_DEF = 10;
   localparam int CFG_WIDTH         = 10;
   localparam int OUT_DATA_WIDTH    = 56;

   typedef enum logic [3:0] {
      PH_METHOD  = 4'd0,
      PH_PATH    = 4'd1,
      PH_VERSION = 4'd2,
      PH_REQ_LF  = 4'd3,
      PH_KEY     = 4'd4,
      PH_VALUE   = 4'd5,
      PH_HDR_LF  = 4'd6,
      PH_END_LF  = 4'd7,
      PH_DONE    = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PATH   = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CAUSE_NONE     = 3'd0,
      CAUSE_METHOD   = 3'd1,
      CAUSE_PATH     = 3'd2,
      CAUSE_VERSION  = 3'd3,
      CAUSE_LINE_END = 3'd4,
      CAUSE_COLON    = 3'd5,
      CAUSE_OVERFLOW = 3'd6,
      CAUSE_LONG     = 3'd7
   } cause_type;

   localparam logic [2:0] MEDIA_NONE    = 3'd0;
   localparam logic [2:0] MEDIA_UNKNOWN = 3'd1;
   localparam logic [2:0] MEDIA_BASE    = 3'd2;

   localparam logic [0:0] REG_MAX_PATH = 1'b0;
   localparam logic [0:0] REG_MAX_LINE = 1'b1;

   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_COLON = 8'h3a;

   localparam int STR_BITS = 8 * 24;
   typedef logic [STR_BITS-1:0] str_type;

   localparam str_type STR_GET     = "GET";
   localparam str_type STR_PUT     = "PUT";
   localparam str_type STR_POST    = "POST";
   localparam str_type STR_VERSION = "HTTP/1.1";
   localparam str_type STR_CTYPE   = "content-type";
   localparam str_type STR_CLEN    = "content-length";
   localparam str_type STR_TEXT    = "text/plain";
   localparam str_type STR_OCTET   = "application/octet-stream";
   localparam str_type STR_JSON    = "application/json";
   localparam str_type STR_TDJSON  = "application/td+json";

   localparam int METH_LEN [3]  = '{3, 3, 4};
   localparam int KEY_LEN [2]   = '{12, 14};
   localparam int MEDIA_LEN [4] = '{10, 24, 16, 19};
   localparam int VERSION_LEN   = 8;

   function automatic logic tok_hit(str_type s, int len, logic [4:0] ti, logic [7:0] c);
      logic hit;
      hit = 1'b0;
      if (int'(ti) < len) begin
         hit = (s[8*(len-1-int'(ti)) +: 8] == c);
      end
      return hit;
   endfunction

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
   endfunction

   function automatic str_type meth_str(int i);
      str_type s;
      unique case (i)
         0: s = STR_GET;
         1: s = STR_PUT;
         default: s = STR_POST;
      endcase
      return s;
   endfunction

   function automatic str_type media_str(int i);
      str_type s;
      unique case (i)
         0: s = STR_TEXT;
         1: s = STR_OCTET;
         2: s = STR_JSON;
         default: s = STR_TDJSON;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/http_request_header_parser_unit.sv =====
// http request header parser, top level
// one byte per beat in, path bytes and one final verdict out; uses hrhp_pkg
`default_nettype none

// Takes one request byte per clock and updates all matchers in one pass, so it
// sustains one byte per cycle when results are taken as they appear. There is a
// single result register: a byte is taken when that register is empty or is
// drained in the same cycle, so a result left waiting on the rsp side stalls the
// input. A byte's result is registered and shows on the rsp side in the cycle after its beat.
// start_of_request (req_tuser) resets the parse before that byte. Registers are
// written through csr_we/csr_index.
module http_request_header_parser_unit
   import hrhp_pkg::*;
#(
   parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
   parameter int MAX_LINE_BITS = MAX_LINE_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,  // byte_value
   input  wire logic                      req_tuser,  // start_of_request
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // path_byte, path_length, method, media_type, body_length, error_cause
   output logic [OUT_DATA_WIDTH-1:0]      rsp_tdata,
   output logic [1:0]                     rsp_tuser,  // result_kind
   input  wire logic                      csr_we,
   input  wire logic [0:0]                csr_index,
   input  wire logic [CFG_WIDTH-1:0]      csr_wdata
);

   localparam int LB  = LENGTH_BITS;
   localparam int MLB = MAX_LINE_BITS;

   logic [7:0]             max_path_ff, max_path_in;
   logic [9:0]             max_line_ff, max_line_in;

   phase_type              phase_ff, phase_in;
   logic [MLB-1:0]         line_count_ff, line_count_in;
   logic [7:0]             path_count_ff, path_count_in;
   logic [4:0]             token_ff, token_in;
   logic [2:0]             meth_cand_ff, meth_cand_in;
   logic [1:0]             key_cand_ff, key_cand_in;
   logic [3:0]             val_cand_ff, val_cand_in;
   logic                   val_started_ff, val_started_in;
   logic                   trail_ff, trail_in;
   logic [LB-1:0]          acc_ff, acc_in;
   logic                   dig_end_ff, dig_end_in;
   logic [1:0]             saved_meth_ff, saved_meth_in;
   logic [2:0]             saved_media_ff, saved_media_in;
   logic [LB-1:0]          saved_len_ff, saved_len_in;

   logic                   out_valid_ff, out_valid_in;
   logic [OUT_DATA_WIDTH-1:0] out_data_ff, out_data_in;
   logic [1:0]             out_kind_ff, out_kind_in;

   logic                   req_acc;
   logic                   res_valid;
   logic                   res_final;
   kind_type               res_kind;
   cause_type              res_cause;
   logic [7:0]             res_byte;
   logic [15:0]            lim, cap16, cfg16;
   logic [7:0]             c, lc;
   logic [LB+3:0]          acc10;
   logic [63:0]            len64;
   logic                   found;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign lc         = to_lower(req_tdata);
   assign cap16      = 16'((32'd1 << MLB) - 32'd1);
   assign cfg16      = 16'(max_line_ff);
   assign lim        = (cfg16 < cap16) ? cfg16 : cap16;

   always_comb begin
      max_path_in = max_path_ff;
      max_line_in = max_line_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MAX_PATH: max_path_in = csr_wdata[7:0];
            REG_MAX_LINE: max_line_in = csr_wdata[9:0];
         endcase
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      line_count_in  = line_count_ff;
      path_count_in  = path_count_ff;
      token_in       = token_ff;
      meth_cand_in   = meth_cand_ff;
      key_cand_in    = key_cand_ff;
      val_cand_in    = val_cand_ff;
      val_started_in = val_started_ff;
      trail_in       = trail_ff;
      acc_in         = acc_ff;
      dig_end_in     = dig_end_ff;
      saved_meth_in  = saved_meth_ff;
      saved_media_in = saved_media_ff;
      saved_len_in   = saved_len_ff;
      res_valid      = 1'b0;
      res_final      = 1'b0;
      res_kind       = KIND_PATH;
      res_cause      = CAUSE_NONE;
      res_byte       = 8'd0;
      found          = 1'b0;
      acc10          = '0;

      if (req_acc) begin
         if (req_tuser) begin
            phase_in       = PH_METHOD;
            line_count_in  = '0;
            path_count_in  = '0;
            token_in       = '0;
            meth_cand_in   = '1;
            key_cand_in    = '1;
            val_cand_in    = '1;
            val_started_in = 1'b0;
            trail_in       = 1'b0;
            acc_in         = '0;
            dig_end_in     = 1'b0;
            saved_meth_in  = '0;
            saved_media_in = '0;
            saved_len_in   = '0;
         end
         if (phase_in != PH_DONE && phase_in <= PH_END_LF) begin
            if (16'(line_count_in) >= lim) begin
               res_final = 1'b1;
               res_kind  = KIND_REJECT;
               res_cause = CAUSE_LONG;
            end else begin
               line_count_in = line_count_in + 1'b1;
               unique case (phase_in)
                  PH_METHOD: begin
                     if (c == CH_SPACE) begin
                        for (int i = 2; i >= 0; i--) begin
                           if (meth_cand_in[i] && int'(token_in) == METH_LEN[i]) begin
                              found         = 1'b1;
                              saved_meth_in = 2'(i);
                           end
                        end
                        if (!found) begin
                           res_final = 1'b1;
                           res_kind  = KIND_REJECT;
                           res_cause = CAUSE_METHOD;
                        end else begin
                           token_in = '0;
                           phase_in = PH_PATH;
                        end
                     end else if (c == CH_CR || c == CH_LF) begin
                        res_final = 1'b1;
                        res_kind  = KIND_REJECT;
                        res_cause = CAUSE_METHOD;
                     end else begin
                        for (int i = 0; i < 3; i++) begin
                           if (!tok_hit(meth_str(i), METH_LEN[i], token_in, c)) begin
                              meth_cand_in[i] = 1'b0;
                           end
                        end
                        if (token_in != 5'd31) token_in = token_in + 1'b1;
                     end
                  end
                  PH_PATH: begin
                     if (c == CH_SPACE) begin
                        token_in = '0;
                        phase_in = PH_VERSION;
                     end else if (c == CH_CR || c == CH_LF) begin
                        res_final = 1'b1;
                        res_kind  = KIND_REJECT;
                        res_cause = CAUSE_LINE_END;
                     end else if (path_count_in >= max_path_ff) begin
                        res_final = 1'b1;
                        res_kind  = KIND_REJECT;
                        res_cause = CAUSE_PATH;
                     end else begin
                        path_count_in = path_count_in + 1'b1;
                        res_valid     = 1'b1;
                        res_kind      = KIND_PATH;
                        res_byte      = c;
                     end
                  end
                  PH_VERSION: begin
                     if (int'(token_in) < VERSION_LEN) begin
                        if (!tok_hit(STR_VERSION, VERSION_LEN, token_in, c)) begin
                           res_final = 1'b1;
                           res_kind  = KIND_REJECT;
                           res_cause = CAUSE_VERSION;
                        end else begin
                           token_in = token_in + 1'b1;
                        end
                     end else if (c != CH_CR) begin
                        res_final = 1'b1;
                        res_kind  = KIND_REJECT;
                        res_cause = CAUSE_VERSION;
                     end else begin
                        phase_in = PH_REQ_LF;
                     end
                  end
                  PH_REQ_LF, PH_HDR_LF: begin
                     if (c != CH_LF) begin
                        res_final = 1'b1;
                        res_kind  = KIND_REJECT;
                        res_cause = CAUSE_LINE_END;
                     end else begin
                        if (phase_in == PH_HDR_LF) begin
                           if (key_cand_in[0]) begin
                              saved_media_in = MEDIA_UNKNOWN;
                              if (val_started_in) begin
                                 for (int i = 3; i >= 0; i--) begin
                                    if (val_cand_in[i] && int'(token_in) == MEDIA_LEN[i]) begin
                                       saved_media_in = MEDIA_BASE + 3'(i);
                                    end
                                 end
                              end
                           end else if (key_cand_in[1]) begin
                              saved_len_in = acc_in;
                           end
                        end
                        line_count_in  = '0;
                        token_in       = '0;
                        key_cand_in    = '1;
                        val_cand_in    = '1;
                        val_started_in = 1'b0;
                        trail_in       = 1'b0;
                        acc_in         = '0;
                        dig_end_in     = 1'b0;
                        phase_in       = PH_KEY;
                     end
                  end
                  PH_KEY: begin
                     if (line_count_in == MLB'(1) && c == CH_CR) begin
                        phase_in = PH_END_LF;
                     end else if (c == CH_COLON) begin
                        if (key_cand_in[0] && int'(token_in) == KEY_LEN[0]) begin
                           key_cand_in = 2'b01;
                        end else if (key_cand_in[1] && int'(token_in) == KEY_LEN[1]) begin
                           key_cand_in = 2'b10;
                        end else begin
                           key_cand_in = 2'b00;
                        end
                        token_in = '0;
                        phase_in = PH_VALUE;
                     end else if (c == CH_CR || c == CH_LF) begin
                        res_final = 1'b1;
                        res_kind  = KIND_REJECT;
                        res_cause = CAUSE_COLON;
                     end else begin
                        if (!tok_hit(STR_CTYPE, KEY_LEN[0], token_in, lc)) key_cand_in[0] = 1'b0;
                        if (!tok_hit(STR_CLEN, KEY_LEN[1], token_in, lc)) key_cand_in[1] = 1'b0;
                        if (token_in != 5'd31) token_in = token_in + 1'b1;
                     end
                  end
                  PH_VALUE: begin
                     if (c == CH_CR) begin
                        phase_in = PH_HDR_LF;
                     end else if (c == CH_LF) begin
                        res_final = 1'b1;
                        res_kind  = KIND_REJECT;
                        res_cause = CAUSE_LINE_END;
                     end else if (c == CH_SPACE || c == CH_TAB) begin
                        if (val_started_in) begin
                           trail_in   = 1'b1;
                           dig_end_in = 1'b1;
                        end
                     end else begin
                        if (trail_in) begin
                           val_cand_in = '0;
                           trail_in    = 1'b0;
                        end
                        val_started_in = 1'b1;
                        for (int i = 0; i < 4; i++) begin
                           if (!tok_hit(media_str(i), MEDIA_LEN[i], token_in, lc)) begin
                              val_cand_in[i] = 1'b0;
                           end
                        end
                        if (token_in != 5'd31) token_in = token_in + 1'b1;
                        if (key_cand_in[1] && !dig_end_in) begin
                           if (c >= 8'h30 && c <= 8'h39) begin
                              acc10 = ((LB+4)'(acc_in) << 3) + ((LB+4)'(acc_in) << 1)
                                    + (LB+4)'(c - 8'h30);
                              if (|acc10[LB+3:LB]) begin
                                 res_final = 1'b1;
                                 res_kind  = KIND_REJECT;
                                 res_cause = CAUSE_OVERFLOW;
                              end else begin
                                 acc_in = acc10[LB-1:0];
                              end
                           end else begin
                              dig_end_in = 1'b1;
                           end
                        end
                     end
                  end
                  PH_END_LF: begin
                     res_final = 1'b1;
                     if (c != CH_LF) begin
                        res_kind  = KIND_REJECT;
                        res_cause = CAUSE_LINE_END;
                     end else begin
                        res_kind  = KIND_ACCEPT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (res_final) begin
               res_valid = 1'b1;
               phase_in  = PH_DONE;
            end
         end
      end
   end

   assign len64 = 64'(saved_len_in);

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_kind_in  = out_kind_ff;
      if (res_valid) begin
         out_valid_in = 1'b1;
         out_kind_in  = res_kind;
         if (res_final) begin
            out_data_in = {res_cause, len64[31:0], saved_media_in, saved_meth_in,
                           path_count_in, 8'd0};
         end else begin
            out_data_in = {48'd0, res_byte};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_path_ff    <= 8'd63;
         max_line_ff    <= 10'd255;
         phase_ff       <= PH_METHOD;
         line_count_ff  <= '0;
         path_count_ff  <= '0;
         token_ff       <= '0;
         meth_cand_ff   <= '1;
         key_cand_ff    <= '1;
         val_cand_ff    <= '1;
         val_started_ff <= 1'b0;
         trail_ff       <= 1'b0;
         acc_ff         <= '0;
         dig_end_ff     <= 1'b0;
         saved_meth_ff  <= '0;
         saved_media_ff <= '0;
         saved_len_ff   <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         max_path_ff    <= max_path_in;
         max_line_ff    <= max_line_in;
         phase_ff       <= phase_in;
         line_count_ff  <= line_count_in;
         path_count_ff  <= path_count_in;
         token_ff       <= token_in;
         meth_cand_ff   <= meth_cand_in;
         key_cand_ff    <= key_cand_in;
         val_cand_ff    <= val_cand_in;
         val_started_ff <= val_started_in;
         trail_ff       <= trail_in;
         acc_ff         <= acc_in;
         dig_end_ff     <= dig_end_in;
         saved_meth_ff  <= saved_meth_in;
         saved_media_ff <= saved_media_in;
         saved_len_ff   <= saved_len_in;
         out_valid_ff   <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_kind_ff <= out_kind_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hrhp_checker.sv =====
// port-level checks for the http request header parser
// bound to http_request_header_parser_unit; uses hrhp_pkg
`default_nettype none

module hrhp_checker
   import hrhp_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [OUT_DATA_WIDTH-1:0] rsp_tdata,
   input wire logic [1:0]                rsp_tuser
);

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // an empty output stage always takes a byte
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // a path beat carries only the byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PATH |-> rsp_tdata[OUT_DATA_WIDTH-1:8] == '0)
      else $error("path beat with final fields");

   // cause set exactly on rejection
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_REJECT) == (rsp_tdata[55:53] != CAUSE_NONE))
                     && rsp_tuser != 2'd3)
      else $error("bad cause or kind");

endmodule

bind http_request_header_parser_unit hrhp_checker u_hrhp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
